FILE: hdl/swq_pkg.sv
// ----------------------------------------------------------------------------
// swq_pkg
// Shared types and codes for the sliding-window quota checker.
// ----------------------------------------------------------------------------
package swq_pkg;

   localparam int TIME_W   = 32;
   localparam int AMOUNT_W = 24;
   localparam int WINDOW_W = 16;
   localparam int TOTAL_W  = 25;
   localparam int VERDICT_W = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   localparam logic [VERDICT_W-1:0] VERDICT_ADMIT = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_OVER  = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_FULL  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUOTA_LIMIT   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SECONDS = 1'd1;

   // Walk token handed from cell to cell.
   typedef struct packed {
      logic               valid;
      logic               stop;
      logic               over;
      logic [TOTAL_W-1:0] total;
   } swq_tok_type;

endpackage

FILE: hdl/sliding_window_quota_check_core.sv
// ----------------------------------------------------------------------------
// sliding_window_quota_check_core
// Sliding-window quota checker built as a shift chain of history cells.
// ----------------------------------------------------------------------------
// The block handles one request at a time. A request is taken when the block
// is idle, a walk token then travels down the chain of HISTORY_DEPTH cells at
// one cell per cycle, the decision is registered and an admitted request is
// recorded when the token comes out of the last cell, and the next request is
// taken only once the result has moved into the output register, where it
// sits until it is taken. Cell zero holds the newest recorded request and the
// last cell the oldest.
module sliding_window_quota_check_core
   import swq_pkg::*;
#(
   parameter int HISTORY_DEPTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TIME_W-1:0]      req_now_seconds,
   input  logic [AMOUNT_W-1:0]    req_request_amount,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VERDICT_W-1:0]   rsp_verdict,
   output logic [TOTAL_W-1:0]     rsp_window_total,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [AMOUNT_W-1:0]  limit_ff;
   logic [WINDOW_W-1:0]  window_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [AMOUNT_W-1:0]  amount_ff;
   logic [CNT_W-1:0]     count_ff;
   swq_tok_type          tok0_ff, tok0_in;
   logic [VERDICT_W-1:0] pend_verdict_ff, pend_verdict_in;
   logic [TOTAL_W-1:0]   pend_total_ff;
   logic                 rsp_valid_ff;
   logic [VERDICT_W-1:0] rsp_verdict_ff;
   logic [TOTAL_W-1:0]   rsp_total_ff;

   swq_tok_type          tok     [HISTORY_DEPTH];
   logic [TIME_W-1:0]    c_time  [HISTORY_DEPTH];
   logic [AMOUNT_W-1:0]  c_amount[HISTORY_DEPTH];
   logic                 live    [HISTORY_DEPTH];

   logic         accept;
   logic         finish;
   logic         full;
   logic         oldest_hit;
   logic         shift_en;
   logic         rsp_free;
   logic [TIME_W-1:0] oldest_age;
   swq_tok_type  tail;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign req_stall = state_ff != ST_IDLE;
   assign tail     = tok[HISTORY_DEPTH-1];
   assign finish   = (state_ff == ST_WALK) && tail.valid;
   assign full     = count_ff == CNT_W'(HISTORY_DEPTH);
   assign oldest_age = now_ff - c_time[HISTORY_DEPTH-1];
   assign oldest_hit = oldest_age <= {{(TIME_W-WINDOW_W){1'b0}}, window_ff};
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (tail.over) begin
         pend_verdict_in = VERDICT_OVER;
      end else if (full && oldest_hit) begin
         pend_verdict_in = VERDICT_FULL;
      end else begin
         pend_verdict_in = VERDICT_ADMIT;
      end
   end

   assign shift_en = finish && (pend_verdict_in == VERDICT_ADMIT);

   always_comb begin
      tok0_in.valid = accept;
      tok0_in.total = {{(TOTAL_W-AMOUNT_W){1'b0}}, req_request_amount};
      tok0_in.over  = req_request_amount > limit_ff;
      tok0_in.stop  = req_request_amount > limit_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (tail.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   genvar k;
   generate
      for (k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
         assign live[k] = count_ff > CNT_W'(k);
         if (k == 0) begin : g_head
            swq_cell u_cell (
               .clock          (clock),
               .reset          (reset),
               .live           (live[k]),
               .window_seconds (window_ff),
               .quota_limit    (limit_ff),
               .now_seconds    (now_ff),
               .shift_en       (shift_en),
               .shift_time     (now_ff),
               .shift_amount   (amount_ff),
               .prev_tok       (tok0_ff),
               .cell_tok       (tok[k]),
               .time_out       (c_time[k]),
               .amount_out     (c_amount[k])
            );
         end else begin : g_body
            swq_cell u_cell (
               .clock          (clock),
               .reset          (reset),
               .live           (live[k]),
               .window_seconds (window_ff),
               .quota_limit    (limit_ff),
               .now_seconds    (now_ff),
               .shift_en       (shift_en),
               .shift_time     (c_time[k-1]),
               .shift_amount   (c_amount[k-1]),
               .prev_tok       (tok[k-1]),
               .cell_tok       (tok[k]),
               .time_out       (c_time[k]),
               .amount_out     (c_amount[k])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= '0;
         window_ff    <= WINDOW_W'(1);
         count_ff     <= '0;
         tok0_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tok0_ff.valid <= tok0_in.valid;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_QUOTA_LIMIT:    limit_ff  <= csr_write_data;
               CSR_WINDOW_SECONDS: window_ff <= csr_write_data[WINDOW_W-1:0];
               default: begin
               end
            endcase
         end
         if (shift_en && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      tok0_ff.stop  <= tok0_in.stop;
      tok0_ff.over  <= tok0_in.over;
      tok0_ff.total <= tok0_in.total;
      if (accept) begin
         now_ff    <= req_now_seconds;
         amount_ff <= req_request_amount;
      end
      if (finish) begin
         pend_verdict_ff <= pend_verdict_in;
         pend_total_ff   <= tail.total;
      end
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_verdict_ff <= pend_verdict_ff;
         rsp_total_ff   <= pend_total_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_window_total = rsp_total_ff;

endmodule

FILE: hdl/swq_cell.sv
// ----------------------------------------------------------------------------
// swq_cell
// One history entry of the checker. It holds a time and an amount, shifts
// them to its older neighbor when a request is recorded, and updates the
// walk token as it passes by.
// ----------------------------------------------------------------------------
module swq_cell
   import swq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                live,
   input  logic [WINDOW_W-1:0] window_seconds,
   input  logic [AMOUNT_W-1:0] quota_limit,
   input  logic [TIME_W-1:0]   now_seconds,
   input  logic                shift_en,
   input  logic [TIME_W-1:0]   shift_time,
   input  logic [AMOUNT_W-1:0] shift_amount,
   input  swq_tok_type         prev_tok,
   output swq_tok_type         cell_tok,
   output logic [TIME_W-1:0]   time_out,
   output logic [AMOUNT_W-1:0] amount_out
);

   logic [TIME_W-1:0]   time_ff;
   logic [AMOUNT_W-1:0] amount_ff;
   swq_tok_type         tok_ff;
   swq_tok_type         tok_in;
   logic [TIME_W-1:0]   age;
   logic                hit;
   logic [TOTAL_W-1:0]  sum;

   assign age = now_seconds - time_ff;
   assign hit = age <= {{(TIME_W-WINDOW_W){1'b0}}, window_seconds};
   assign sum = prev_tok.total + {{(TOTAL_W-AMOUNT_W){1'b0}}, amount_ff};

   always_comb begin
      tok_in = prev_tok;
      if (prev_tok.valid && !prev_tok.stop) begin
         if (!live || !hit) begin
            tok_in.stop = 1'b1;
         end else begin
            tok_in.total = sum;
            if (sum > {{(TOTAL_W-AMOUNT_W){1'b0}}, quota_limit}) begin
               tok_in.stop = 1'b1;
               tok_in.over = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.stop  <= tok_in.stop;
      tok_ff.over  <= tok_in.over;
      tok_ff.total <= tok_in.total;
      if (shift_en) begin
         time_ff   <= shift_time;
         amount_ff <= shift_amount;
      end
   end

   assign cell_tok   = tok_ff;
   assign time_out   = time_ff;
   assign amount_out = amount_ff;

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding-window quota checker.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the request history and the two
// settings. It predicts the verdict and the window total of every request
// the block takes and compares them with the responses in order. A short
// directed run covers reset settings, field extremes, time wrap, entries
// stamped after the current time, the amount alone over the limit, a walk
// that goes over quota and a full history still inside the window. Random
// traffic then runs under several settings and four handshake pacing modes.
// It is mostly slowly advancing time stamps with amounts sized to the quota,
// plus some steps back in time, fully random requests and near-limit amounts.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swq_pkg::*;

   localparam int HISTORY_DEPTH     = 16;
   localparam int ITEMS_PER_SETTING = 110;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [TOTAL_W-1:0]   total;
   } quota_outcome_type;

   class quota_scoreboard;
      logic [TIME_W-1:0]   entry_time   [HISTORY_DEPTH];
      logic [AMOUNT_W-1:0] entry_amount [HISTORY_DEPTH];
      int                  newest_slot;
      int                  entry_count;
      logic [AMOUNT_W-1:0] quota_limit;
      logic [WINDOW_W-1:0] window_seconds;
      quota_outcome_type   pending_outcomes[$];
      int                  mismatches;
      int                  verdict_seen[3];

      function new();
         newest_slot    = 0;
         entry_count    = 0;
         quota_limit    = '0;
         window_seconds = 1;
         mismatches     = 0;
         foreach (verdict_seen[i]) verdict_seen[i] = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
         if (index == CSR_QUOTA_LIMIT) begin
            quota_limit = data[AMOUNT_W-1:0];
         end else if (index == CSR_WINDOW_SECONDS) begin
            window_seconds = data[WINDOW_W-1:0];
         end
      endfunction

      function bit in_window(logic [TIME_W-1:0] now, int slot);
         logic [TIME_W-1:0] age;
         age = now - entry_time[slot];
         return age <= window_seconds;
      endfunction

      function void note_request(logic [TIME_W-1:0] now, logic [AMOUNT_W-1:0] amount);
         quota_outcome_type  outcome;
         logic [TOTAL_W-1:0] sum;
         int                 slot;
         int                 next_slot;
         int                 k;
         bit                 walking;
         sum = amount;
         outcome.verdict = VERDICT_ADMIT;
         if (sum > quota_limit) begin
            outcome.verdict = VERDICT_OVER;
         end else begin
            walking = 1'b1;
            for (k = 0; k < entry_count && walking; k++) begin
               slot = (newest_slot + HISTORY_DEPTH - k) % HISTORY_DEPTH;
               if (!in_window(now, slot)) begin
                  walking = 1'b0;
               end else begin
                  sum = sum + entry_amount[slot];
                  if (sum > quota_limit) begin
                     outcome.verdict = VERDICT_OVER;
                     walking = 1'b0;
                  end
               end
            end
         end
         if (outcome.verdict == VERDICT_ADMIT) begin
            next_slot = (newest_slot + 1) % HISTORY_DEPTH;
            if (entry_count == HISTORY_DEPTH && in_window(now, next_slot)) begin
               outcome.verdict = VERDICT_FULL;
            end else begin
               entry_time[next_slot]   = now;
               entry_amount[next_slot] = amount;
               newest_slot = next_slot;
               if (entry_count < HISTORY_DEPTH) entry_count++;
            end
         end
         outcome.total = sum;
         pending_outcomes.push_back(outcome);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < 20) $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic [VERDICT_W-1:0] verdict, logic [TOTAL_W-1:0] total);
         quota_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("response with no request waiting, verdict %0d total %0d",
                                      verdict, total));
         end else begin
            want = pending_outcomes.pop_front();
            if (want.verdict <= VERDICT_FULL) verdict_seen[want.verdict]++;
            if (verdict !== want.verdict)
               report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want.verdict));
            if (total !== want.total)
               report_mismatch($sformatf("window total %0d, expected %0d", total, want.total));
         end
      endtask
   endclass

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [TIME_W-1:0]      req_now_seconds    = '0;
   logic [AMOUNT_W-1:0]    req_request_amount = '0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [VERDICT_W-1:0]   rsp_verdict;
   logic [TOTAL_W-1:0]     rsp_window_total;
   logic                   csr_write_enable   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data     = '0;

   quota_scoreboard board = new();

   int unsigned       quota_setting      = 0;
   int unsigned       window_setting     = 1;
   logic [TIME_W-1:0] stamp              = '0;
   int                sender_idle_pct    = 0;
   int                receiver_stall_pct = 0;
   int                requests_sent      = 0;
   int                settings_used      = 0;

   sliding_window_quota_check_core #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_seconds   (req_now_seconds),
      .req_request_amount(req_request_amount),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_verdict       (rsp_verdict),
      .rsp_window_total  (rsp_window_total),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_verdict, rsp_window_total);
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   task automatic send_request(logic [TIME_W-1:0] now, logic [AMOUNT_W-1:0] amount);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_now_seconds    <= now;
      req_request_amount <= amount;
      do @(posedge clock); while (req_stall);
      board.note_request(now, amount);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_settings(int unsigned limit, int unsigned window);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_QUOTA_LIMIT;
      csr_write_data   <= CSR_DATA_W'(limit);
      @(posedge clock);
      board.set_register(CSR_QUOTA_LIMIT, CSR_DATA_W'(limit));
      csr_index        <= CSR_WINDOW_SECONDS;
      csr_write_data   <= CSR_DATA_W'(window);
      @(posedge clock);
      board.set_register(CSR_WINDOW_SECONDS, CSR_DATA_W'(window));
      csr_write_enable <= 1'b0;
      quota_setting  = limit & 32'hFF_FFFF;
      window_setting = window & 32'hFFFF;
      settings_used++;
   endtask

   task automatic run_directed();
      int i;
      send_request(32'd0, 24'd0);
      send_request(32'd1, 24'hFF_FFFF);
      send_request(32'd2, 24'd1);
      wait_idle();
      write_settings(100, 0);
      send_request(32'd5, 24'd100);
      send_request(32'd5, 24'd1);
      send_request(32'd6, 24'd50);
      send_request(32'd3, 24'd100);
      wait_idle();
      write_settings(32'hFF_FFFF, 32'hFFFF);
      send_request(32'd100, 24'hFF_FFFF);
      for (i = 0; i < HISTORY_DEPTH; i++) send_request(32'hFFFF_FFF8 + i, 24'd0);
      send_request(32'd8, 24'd0);
      stamp = 32'd8;
   endtask

   task automatic run_random(int count);
      int unsigned         step_max;
      int unsigned         amount_max;
      int unsigned         pick;
      logic [AMOUNT_W-1:0] amount;
      step_max   = window_setting / 3 + 1;
      amount_max = quota_setting / 4 + 1;
      repeat (count) begin
         pick   = $urandom_range(0, 99);
         amount = AMOUNT_W'($urandom_range(0, amount_max));
         if (pick < 78) begin
            stamp = stamp + $urandom_range(0, step_max);
         end else if (pick < 86) begin
            stamp = stamp - $urandom_range(1, step_max);
         end else if (pick < 94) begin
            stamp  = $urandom;
            amount = AMOUNT_W'($urandom);
         end else begin
            amount = AMOUNT_W'(quota_setting + 1 - $urandom_range(0, 2));
         end
         send_request(stamp, amount);
      end
   endtask

   initial begin
      int mode;
      int phase;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 48;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 48;
            end
            default: begin
               sender_idle_pct    = 10;
               receiver_stall_pct = 10;
            end
         endcase
         for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
               0: write_settings($urandom_range(1, 5000), $urandom_range(0, 30));
               1: write_settings(32'hFF_FFFF, 0);
               2: write_settings($urandom & 32'hFF_FFFF, 32'hFFFF);
               default: begin
                  write_settings((mode == 0) ? 0 : $urandom_range(1, 64),
                                 $urandom_range(1, 65535));
               end
            endcase
            run_random(ITEMS_PER_SETTING);
         end
      end
      wait_idle();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (HISTORY_DEPTH + 8) @(posedge clock);
      $display("Ran %0d requests through %0d quota and window settings in four pacing modes.",
               requests_sent, settings_used);
      $display("Responses checked: %0d admitted, %0d over quota, %0d refused on full history.",
               board.verdict_seen[VERDICT_ADMIT], board.verdict_seen[VERDICT_OVER],
               board.verdict_seen[VERDICT_FULL]);
      if (board.mismatches == 0) begin
         $display("sliding_window_quota_check_core test passed");
      end else begin
         $display("sliding_window_quota_check_core test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d responses outstanding.", board.pending_outcomes.size());
      $display("sliding_window_quota_check_core test failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/swq_pkg.sv
hdl/swq_cell.sv
hdl/sliding_window_quota_check_core.sv
verif/tb.sv
